// ----- src/keypad_tone_sequencer_assert.svh -----
// Assertion helpers for the keypad tone sequencer.
`ifndef KEYPAD_TONE_SEQUENCER_ASSERT_SVH
`define KEYPAD_TONE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define KTS_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");
`define KTS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define KTS_ASSERT_IMPLY(label, clk, rst, a, c)
`define KTS_ASSERT_NEXT(label, clk, rst, a, c)
`endif

`endif

// ----- src/kts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package kts_pkg;

  localparam int TICK_HZ    = 1000000;
  localparam int OCTAVE_TOP = 8;

  // quotient width follows the tick rate, bit counter width the quotient width
  localparam int QW = $clog2(TICK_HZ + 1);
  localparam int CW = $clog2(QW);
  localparam int FW = 13;

  localparam logic [12:0] LEN_MAX   = 13'd5000;
  localparam logic [12:0] LEN_MIN   = 13'd100;
  localparam logic [12:0] LEN_STEP  = 13'd100;
  localparam logic [12:0] LEN_RESET = 13'd1000;
  localparam logic [3:0]  OCT_RESET = 4'd4;
  localparam logic [3:0]  OCT_TOP   = 4'(OCTAVE_TOP);
  localparam logic [2:0]  NOTE_LAST = 3'd6;

  localparam logic [3:0] KEY_NONE  = 4'd0;
  localparam logic [3:0] KEY_NOTE1 = 4'd1;
  localparam logic [3:0] KEY_NOTE7 = 4'd7;
  localparam logic [3:0] KEY_LONG  = 4'd8;
  localparam logic [3:0] KEY_SHORT = 4'd9;
  localparam logic [3:0] KEY_OCTUP = 4'd10;
  localparam logic [3:0] KEY_OCTDN = 4'd11;
  localparam logic [3:0] KEY_SCALE = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_DIV,
    ST_WRAP,
    ST_EMIT
  } state_t;

  function automatic logic [FW-1:0] base_freq(input logic [2:0] idx);
    logic [FW-1:0] f;
    case (idx)
      3'd0: f = FW'(262);
      3'd1: f = FW'(294);
      3'd2: f = FW'(330);
      3'd3: f = FW'(349);
      3'd4: f = FW'(392);
      3'd5: f = FW'(440);
      default: f = FW'(494);
    endcase
    return f;
  endfunction

  // base frequency moved by (octave - 4) octaves
  function automatic logic [FW-1:0] note_freq(input logic [2:0] idx, input logic [3:0] oct);
    logic [FW-1:0] b;
    logic [FW-1:0] f;
    b = base_freq(idx);
    if (oct >= OCT_RESET) begin
      f = b << (oct - OCT_RESET);
    end else begin
      f = b >> (OCT_RESET - oct);
    end
    return f;
  endfunction

endpackage
`default_nettype wire

// ----- src/keypad_tone_sequencer.sv -----
// An item that starts no note passes through ST_PROC and ST_EMIT; one that
//   starts a note runs the bit-serial period divider in ST_DIV and ST_WRAP
//   between them. One item at a time: a new one is taken only in ST_IDLE,
//   and ST_EMIT waits while an earlier result is still held on the output.
// Reset (rst, synchronous): octave 4, duration 1000 ms, tone off, no scale.
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_tone_sequencer_assert.svh"
module keypad_tone_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // key[3:0], zero fill
  input  wire logic        s_tuser,  // func: 0 tick, 1 key press
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata   // sound_on, reload[16], compare[16], note[3],
                                     // octave[4], length_ms[13], limit_hit,
                                     // scale_running, zero fill
);

  kts_pkg::state_t state, state_next;

  logic                  func_r;
  logic [3:0]            key_r;
  logic [3:0]            octave_level;
  logic [12:0]           note_length;
  logic                  single_active;
  logic [12:0]           single_left;
  logic                  scale_active;
  logic [2:0]            scale_step;
  logic [12:0]           scale_left;
  logic [15:0]           period_reg;
  logic [15:0]           compare_reg;
  logic [2:0]            last_note;
  logic                  limit;

  logic [kts_pkg::FW-1:0] fdiv;
  logic [kts_pkg::FW-1:0] rem;
  logic [kts_pkg::QW-1:0] quo;
  logic [kts_pkg::CW-1:0] cnt;

  logic                   need_div;
  logic [2:0]             div_idx;
  logic                   div_load;
  logic                   emit_load;

  localparam logic [kts_pkg::QW-1:0] TICK_VEC = kts_pkg::QW'(kts_pkg::TICK_HZ);

  // one restoring-division step per cycle
  logic [kts_pkg::FW:0]   shifted;
  logic                   ge;
  logic [kts_pkg::FW:0]   diff;
  assign shifted = {rem, TICK_VEC[cnt]};
  assign ge      = shifted >= {1'b0, fdiv};
  assign diff    = shifted - {1'b0, fdiv};

  logic [12:0] single_dec;
  logic [12:0] scale_dec;
  logic [2:0]  step_inc;
  assign single_dec = single_left - 13'd1;
  assign scale_dec  = scale_left - 13'd1;
  assign step_inc   = scale_step + 3'd1;

  logic is_note_key;
  assign is_note_key = key_r >= kts_pkg::KEY_NOTE1 && key_r <= kts_pkg::KEY_NOTE7;

  always_comb begin
    need_div = 1'b0;
    div_idx  = 3'd0;
    if (!func_r) begin
      if (scale_active && scale_dec == 13'd0 && scale_step < kts_pkg::NOTE_LAST) begin
        need_div = 1'b1;
        div_idx  = step_inc;
      end
    end else if (is_note_key) begin
      need_div = 1'b1;
      div_idx  = 3'(key_r - 4'd1);
    end else if (key_r == kts_pkg::KEY_SCALE) begin
      need_div = 1'b1;
      div_idx  = 3'd0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kts_pkg::ST_IDLE: if (s_tvalid) state_next = kts_pkg::ST_PROC;
      kts_pkg::ST_PROC: state_next = need_div ? kts_pkg::ST_DIV : kts_pkg::ST_EMIT;
      kts_pkg::ST_DIV:  if (cnt == '0) state_next = kts_pkg::ST_WRAP;
      kts_pkg::ST_WRAP: state_next = kts_pkg::ST_EMIT;
      kts_pkg::ST_EMIT: if (!m_tvalid || m_tready) state_next = kts_pkg::ST_IDLE;
      default:          state_next = kts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = state == kts_pkg::ST_IDLE;
    div_load  = state == kts_pkg::ST_PROC && need_div;
    emit_load = state == kts_pkg::ST_EMIT && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_r <= s_tuser;
      key_r  <= s_tdata[3:0];
    end
    if (div_load) begin
      fdiv <= kts_pkg::note_freq(div_idx, octave_level);
      rem  <= '0;
      quo  <= '0;
      cnt  <= kts_pkg::CW'(kts_pkg::QW - 1);
    end else if (state == kts_pkg::ST_DIV) begin
      rem <= ge ? diff[kts_pkg::FW-1:0] : shifted[kts_pkg::FW-1:0];
      quo <= {quo[kts_pkg::QW-2:0], ge};
      cnt <= cnt - kts_pkg::CW'(1);
    end
  end

  logic [15:0] period_new;
  logic [16:0] period_inc;
  assign period_new = (fdiv == '0) ? 16'hFFFF : quo[15:0] - 16'd1;
  assign period_inc = {1'b0, period_new} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_level  <= kts_pkg::OCT_RESET;
      note_length   <= kts_pkg::LEN_RESET;
      single_active <= 1'b0;
      single_left   <= '0;
      scale_active  <= 1'b0;
      scale_step    <= '0;
      scale_left    <= '0;
      period_reg    <= '0;
      compare_reg   <= '0;
      last_note     <= '0;
      limit         <= 1'b0;
    end else if (state == kts_pkg::ST_PROC) begin
      limit <= 1'b0;
      if (div_load) last_note <= div_idx;
      if (!func_r) begin
        if (single_active) begin
          single_left <= single_dec;
          if (single_dec == 13'd0) begin
            compare_reg   <= '0;
            single_active <= 1'b0;
          end
        end
        if (scale_active) begin
          scale_left <= scale_dec;
          if (scale_dec == 13'd0) begin
            scale_step <= step_inc;
            if (scale_step < kts_pkg::NOTE_LAST) begin
              scale_left <= note_length;
            end else begin
              scale_active  <= 1'b0;
              compare_reg   <= '0;
              single_active <= 1'b0;
            end
          end
        end
      end else if (key_r != kts_pkg::KEY_NONE) begin
        if (scale_active) begin
          scale_active  <= 1'b0;
          compare_reg   <= '0;
          single_active <= 1'b0;
        end
        if (is_note_key) begin
          single_active <= 1'b1;
          single_left   <= note_length;
        end else begin
          case (key_r)
            kts_pkg::KEY_LONG: begin
              if (note_length < kts_pkg::LEN_MAX) note_length <= note_length + kts_pkg::LEN_STEP;
              else limit <= 1'b1;
            end
            kts_pkg::KEY_SHORT: begin
              if (note_length > kts_pkg::LEN_MIN) note_length <= note_length - kts_pkg::LEN_STEP;
              else limit <= 1'b1;
            end
            kts_pkg::KEY_OCTUP: begin
              if (octave_level >= kts_pkg::OCT_TOP) limit <= 1'b1;
              else octave_level <= octave_level + 4'd1;
            end
            kts_pkg::KEY_OCTDN: begin
              if (octave_level == 4'd0) limit <= 1'b1;
              else octave_level <= octave_level - 4'd1;
            end
            kts_pkg::KEY_SCALE: begin
              scale_step   <= '0;
              scale_active <= 1'b1;
              scale_left   <= note_length;
            end
            default: begin
            end
          endcase
        end
      end
    end else if (state == kts_pkg::ST_WRAP) begin
      period_reg  <= period_new;
      compare_reg <= period_inc[16:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_tdata <= {1'b0, scale_active, limit, note_length, octave_level, last_note,
                  compare_reg, period_reg, compare_reg != 16'd0};
    end
  end

  `KTS_ASSERT_IMPLY(a_len_range, clk, rst, 1'b1, note_length >= kts_pkg::LEN_MIN && note_length <= kts_pkg::LEN_MAX)
  `KTS_ASSERT_IMPLY(a_scale_step, clk, rst, scale_active, scale_step <= kts_pkg::NOTE_LAST)
  `KTS_ASSERT_NEXT(a_accept_proc, clk, rst, s_tvalid && s_tready, state == kts_pkg::ST_PROC)
  `KTS_ASSERT_NEXT(a_div_end, clk, rst, state == kts_pkg::ST_DIV && cnt == '0, state == kts_pkg::ST_WRAP)
  `KTS_ASSERT_NEXT(a_emit_valid, clk, rst, emit_load, m_tvalid && state == kts_pkg::ST_IDLE)

endmodule
`default_nettype wire

// ----- test/tb_keypad_tone_sequencer.sv -----
`timescale 1ns / 1ps
module tb_keypad_tone_sequencer;

  typedef struct {
    bit       func;  // 0 tick, 1 key press
    bit [3:0] key;
  } key_event_t;

  typedef struct {
    bit        sound_on;
    bit [15:0] reload;
    bit [15:0] compare;
    bit [2:0]  note;
    bit [3:0]  octave;
    bit [12:0] length_ms;
    bit        limit_hit;
    bit        scale_running;
  } tone_status_t;

  localparam int RANDOM_EVENTS = 1950;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  key_event_t   pending_events[$];
  tone_status_t expected_status[$];
  int           n_errors;
  int           n_accepted;
  int           n_random;
  bit           item_taken;
  bit [12:0]    planned_len;  // note length as the stimulus side tracks it

  // predictor state
  bit [3:0]  oct_lvl;
  bit [12:0] note_len;
  bit        single_on;
  bit [12:0] single_cnt;
  bit        scale_on;
  bit [2:0]  scale_idx;
  bit [12:0] scale_cnt;
  bit [15:0] reload_r;
  bit [15:0] compare_r;
  bit [2:0]  last_idx;

  keypad_tone_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    n_errors++;
    $display("%0t %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic bit [31:0] scale_base_hz(input bit [2:0] idx);
    case (idx)
      3'd0: return 262;
      3'd1: return 294;
      3'd2: return 330;
      3'd3: return 349;
      3'd4: return 392;
      3'd5: return 440;
      default: return 494;
    endcase
  endfunction

  task automatic start_tone(input bit [2:0] idx);
    bit [31:0] f;
    bit [31:0] q;
    f = scale_base_hz(idx);
    if (oct_lvl >= kts_pkg::OCT_RESET) begin
      f = f << (oct_lvl - kts_pkg::OCT_RESET);
    end else begin
      f = f >> (kts_pkg::OCT_RESET - oct_lvl);
    end
    q = (f == 0) ? 32'd0 : 32'(kts_pkg::TICK_HZ) / f;
    reload_r = 16'(q - 1);
    compare_r = 16'((17'(reload_r) + 17'd1) >> 1);
    last_idx = idx;
  endtask

  task automatic mute_tone();
    compare_r = '0;
    single_on = 1'b0;
  endtask

  task automatic advance_tone_state(input bit func, input bit [3:0] key);
    tone_status_t r;
    bit limit;
    limit = 1'b0;
    if (!func) begin
      if (single_on) begin
        single_cnt = single_cnt - 13'd1;
        if (single_cnt == 0) mute_tone();
      end
      if (scale_on) begin
        scale_cnt = scale_cnt - 13'd1;
        if (scale_cnt == 0) begin
          scale_idx = scale_idx + 3'd1;
          if (scale_idx <= kts_pkg::NOTE_LAST) begin
            start_tone(scale_idx);
            scale_cnt = note_len;
          end else begin
            scale_on = 1'b0;
            mute_tone();
          end
        end
      end
    end else if (key != kts_pkg::KEY_NONE) begin
      // any press stops a running scale before the key acts
      if (scale_on) begin
        scale_on = 1'b0;
        mute_tone();
      end
      if (key >= kts_pkg::KEY_NOTE1 && key <= kts_pkg::KEY_NOTE7) begin
        start_tone(3'(key - kts_pkg::KEY_NOTE1));
        single_on = 1'b1;
        single_cnt = note_len;
      end else if (key == kts_pkg::KEY_LONG) begin
        if (note_len < kts_pkg::LEN_MAX) note_len = note_len + kts_pkg::LEN_STEP;
        else limit = 1'b1;
      end else if (key == kts_pkg::KEY_SHORT) begin
        if (note_len > kts_pkg::LEN_MIN) note_len = note_len - kts_pkg::LEN_STEP;
        else limit = 1'b1;
      end else if (key == kts_pkg::KEY_OCTUP) begin
        if (oct_lvl >= kts_pkg::OCT_TOP) limit = 1'b1;
        else oct_lvl = oct_lvl + 4'd1;
      end else if (key == kts_pkg::KEY_OCTDN) begin
        if (oct_lvl == 0) limit = 1'b1;
        else oct_lvl = oct_lvl - 4'd1;
      end else if (key == kts_pkg::KEY_SCALE) begin
        scale_idx = '0;
        scale_on = 1'b1;
        start_tone(3'd0);
        scale_cnt = note_len;
      end
    end
    r.sound_on = (compare_r != 0);
    r.reload = reload_r;
    r.compare = compare_r;
    r.note = last_idx;
    r.octave = oct_lvl;
    r.length_ms = note_len;
    r.limit_hit = limit;
    r.scale_running = scale_on;
    expected_status.push_back(r);
  endtask

  task automatic push_ticks(input int n);
    key_event_t ev;
    ev.func = 1'b0;
    ev.key = 4'($urandom_range(0, 15));  // key field is don't-care on ticks
    repeat (n) begin
      pending_events.push_back(ev);
      n_random++;
    end
  endtask

  task automatic push_key(input bit [3:0] k);
    key_event_t ev;
    ev.func = 1'b1;
    ev.key = k;
    pending_events.push_back(ev);
    if (k != kts_pkg::KEY_NONE) n_random++;
    if (k == kts_pkg::KEY_LONG && planned_len < kts_pkg::LEN_MAX)
      planned_len = planned_len + kts_pkg::LEN_STEP;
    if (k == kts_pkg::KEY_SHORT && planned_len > kts_pkg::LEN_MIN)
      planned_len = planned_len - kts_pkg::LEN_STEP;
  endtask

  task automatic push_full_scale();
    while (planned_len > kts_pkg::LEN_MIN) push_key(kts_pkg::KEY_SHORT);
    // a single note still counting when the scale starts
    if ($urandom_range(0, 1)) begin
      push_key(4'($urandom_range(kts_pkg::KEY_NOTE1, kts_pkg::KEY_NOTE7)));
      push_ticks($urandom_range(1, 60));
    end
    push_key(kts_pkg::KEY_SCALE);
    push_ticks(7 * kts_pkg::LEN_MIN + $urandom_range(0, 5));
  endtask

  function automatic int sender_idle_pct(input int phase);
    return (phase == 1) ? 46 : (phase == 3) ? 33 : 0;
  endfunction

  function automatic int receiver_stall_pct(input int phase);
    return (phase == 2) ? 46 : (phase == 3) ? 33 : 0;
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    key_event_t ev;
    int phase;
    phase = (n_accepted / 250) % 4;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct(phase));
      if (!s_tvalid || item_taken) begin
        item_taken = 1'b0;
        if (pending_events.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct(phase)) begin
          ev = pending_events.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, ev.key};
          s_tuser <= ev.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // input accept and output check on the rising edge
  always @(posedge clk) begin
    tone_status_t w;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        advance_tone_state(s_tuser, s_tdata[3:0]);
        item_taken = 1'b1;
        n_accepted++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected output item", m_tdata, 0);
        end else begin
          w = expected_status.pop_front();
          if (m_tdata[0] != w.sound_on) report_mismatch("sound_on", m_tdata[0], w.sound_on);
          if (m_tdata[16:1] != w.reload) report_mismatch("reload", m_tdata[16:1], w.reload);
          if (m_tdata[32:17] != w.compare) report_mismatch("compare", m_tdata[32:17], w.compare);
          if (m_tdata[35:33] != w.note) report_mismatch("note", m_tdata[35:33], w.note);
          if (m_tdata[39:36] != w.octave) report_mismatch("octave", m_tdata[39:36], w.octave);
          if (m_tdata[52:40] != w.length_ms)
            report_mismatch("length_ms", m_tdata[52:40], w.length_ms);
          if (m_tdata[53] != w.limit_hit) report_mismatch("limit_hit", m_tdata[53], w.limit_hit);
          if (m_tdata[54] != w.scale_running)
            report_mismatch("scale_running", m_tdata[54], w.scale_running);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("keypad_tone_sequencer: mismatch");
    $finish;
  end

  initial begin
    int roll;
    bit [3:0] k;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    n_errors = 0;
    n_accepted = 0;
    n_random = 0;
    item_taken = 1'b0;
    oct_lvl = kts_pkg::OCT_RESET;
    note_len = kts_pkg::LEN_RESET;
    single_on = 1'b0;
    single_cnt = '0;
    scale_on = 1'b0;
    scale_idx = '0;
    scale_cnt = '0;
    reload_r = '0;
    compare_r = '0;
    last_idx = '0;
    planned_len = kts_pkg::LEN_RESET;

    // directed: idle tick, no key, unused keys, every note and control key,
    // then a scale cut short by a press
    push_ticks(1);
    push_key(kts_pkg::KEY_NONE);
    push_key(4'd13);
    push_key(4'd15);
    for (int i = kts_pkg::KEY_NOTE1; i <= kts_pkg::KEY_NOTE7; i++) push_key(4'(i));
    push_key(kts_pkg::KEY_LONG);
    push_key(kts_pkg::KEY_SHORT);
    push_key(kts_pkg::KEY_OCTUP);
    push_key(kts_pkg::KEY_OCTDN);
    push_key(kts_pkg::KEY_SCALE);
    push_ticks(2);
    push_key(4'd14);
    push_key(4'd4);
    push_ticks(1);

    n_random = 0;
    push_full_scale();
    while (n_random < RANDOM_EVENTS) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        push_key(4'($urandom_range(0, 15)));
      end else if (roll < 35) begin
        // duration runs, biased toward short notes; long runs reach both bounds
        k = ($urandom_range(0, 99) < 70) ? kts_pkg::KEY_SHORT : kts_pkg::KEY_LONG;
        repeat ($urandom_range(1, 45)) push_key(k);
      end else if (roll < 45) begin
        k = $urandom_range(0, 1) ? kts_pkg::KEY_OCTUP : kts_pkg::KEY_OCTDN;
        repeat ($urandom_range(1, 10)) push_key(k);
      end else if (roll < 55) begin
        if (planned_len == kts_pkg::LEN_MIN && $urandom_range(0, 3) == 0) begin
          push_full_scale();
        end else begin
          if ($urandom_range(0, 1))
            push_key(4'($urandom_range(kts_pkg::KEY_NOTE1, kts_pkg::KEY_NOTE7)));
          push_key(kts_pkg::KEY_SCALE);
          push_ticks($urandom_range(1, 250));
          push_key(4'($urandom_range(0, 15)));
        end
      end else if (roll < 70) begin
        push_key(4'($urandom_range(kts_pkg::KEY_NOTE1, kts_pkg::KEY_NOTE7)));
        push_ticks($urandom_range(1, (planned_len <= 200) ? planned_len + 3 : 150));
      end else begin
        push_ticks($urandom_range(1, 20));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_events.size() != 0 || s_tvalid || expected_status.size() != 0) begin
      @(negedge clk);
    end
    repeat (40) @(posedge clk);
    if (n_errors == 0 && expected_status.size() == 0) begin
      $display("keypad_tone_sequencer: match");
    end else begin
      $display("keypad_tone_sequencer: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/kts_pkg.sv
src/keypad_tone_sequencer.sv
test/tb_keypad_tone_sequencer.sv
